// File: rtl/core/ldt_pkg.sv
// lane delay training package: parameter defaults, command and register codes
// shared by the training core, the divider and the port checker
`default_nettype none

package ldt_pkg;

    localparam int LDT_DELAY_TAPS = 32;
    localparam int LDT_MAX_LANES  = 8;
    localparam int LDT_SLIP_TRIES = 4;

    localparam int LDT_ADDR_W = 4;
    localparam int LDT_DATA_W = 32;

    localparam logic [1:0] CMD_WRITE_READ = 2'd0;
    localparam logic [1:0] CMD_READ       = 2'd1;
    localparam logic [1:0] CMD_NONE       = 2'd2;

    localparam logic OP_START     = 1'b0;
    localparam logic OP_READ_BACK = 1'b1;

    localparam logic [1:0] REG_LANES_IN_USE   = 2'd0;
    localparam logic [1:0] REG_FALLBACK_DELAY = 2'd1;
    localparam logic [1:0] REG_LOCK_RUN       = 2'd2;
    localparam logic [1:0] REG_PATTERN        = 2'd3;

    localparam logic [3:0]  RST_LANES_IN_USE   = 4'd8;
    localparam logic [4:0]  RST_FALLBACK_DELAY = 5'd9;
    localparam logic [4:0]  RST_LOCK_RUN       = 5'd4;
    localparam logic [31:0] RST_PATTERN        = 32'hFFAA5500;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

// File: rtl/core/ldt_divider.sv
// serial restoring divider, one quotient bit per cycle
// depends on ldt_pkg for the status struct
`default_nettype none

module ldt_divider
    import ldt_pkg::*;
#(
    parameter int DIVD_W = 9,
    parameter int DIVR_W = 6
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DIVD_W-1:0] dividend,
    input  wire logic [DIVR_W-1:0] divisor,
    output logic      [DIVD_W-1:0] quotient,
    output div_status_t            status
);

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic [DIVR_W-1:0] rem_reg, rem_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [DIVR_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DIVR_W:0]   shifted;
    logic [DIVR_W:0]   trial;
    logic              qbit;
    logic [DIVD_W:0]   quo_shift;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIVD_W-1]};
        trial     = shifted - {1'b0, dsr_reg};
        qbit      = (shifted >= {1'b0, dsr_reg});
        quo_shift = {quo_reg, qbit};

        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(DIVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? trial[DIVR_W-1:0] : shifted[DIVR_W-1:0];
            quo_next = quo_shift[DIVD_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

// File: rtl/core/lane_delay_training_with_bitslip_core.sv
// lane delay training core: tap scan, window mean, bitslip alignment, apb registers
// depends on ldt_pkg and ldt_divider
// a result is held in the pending result word after accept, then loaded into the output
// register; a scan ending on a matched window first waits for the serial divider to form
// the mean tap; input stalls until the output register loads the result; the output register
// frees the input while one result waits; reset clears control state, loads defaults
`default_nettype none

module lane_delay_training_with_bitslip_core
    import ldt_pkg::*;
#(
    parameter int DELAY_TAPS = LDT_DELAY_TAPS,
    parameter int MAX_LANES  = LDT_MAX_LANES,
    parameter int SLIP_TRIES = LDT_SLIP_TRIES,
    localparam int TAP_W  = $clog2(DELAY_TAPS),
    localparam int LANE_W = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [LDT_ADDR_W-1:0] paddr,
    input  wire logic [LDT_DATA_W-1:0] pwdata,
    output logic      [LDT_DATA_W-1:0] prdata,
    output logic                       pready,

    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  operation,
    input  wire logic [31:0]           test_word,

    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic      [1:0]            command,
    output logic                       pulse_bitslip,
    output logic      [LANE_W-1:0]     lane,
    output logic      [TAP_W-1:0]      delay,
    output logic                       report_valid,
    output logic      [LANE_W-1:0]     report_lane,
    output logic                       report_aligned,
    output logic      [TAP_W-1:0]      report_delay,
    output logic                       training_done
);

    localparam int RUN_W  = $clog2(DELAY_TAPS + 1);
    localparam int SUM_W  = $clog2(DELAY_TAPS * (DELAY_TAPS - 1) / 2 + 1);
    localparam int SLIP_W = $clog2(SLIP_TRIES + 1);
    localparam int CMP_W  = (RUN_W > 5) ? RUN_W : 5;

    localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(DELAY_TAPS - 1);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SCAN = 2'd1;
    localparam logic [1:0] PH_SLIP = 2'd2;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    // configuration registers
    logic [3:0]  lanes_reg;
    logic [4:0]  fallback_reg;
    logic [4:0]  lock_reg;
    logic [31:0] pattern_reg;
    logic        cfg_write;

    // training state
    logic [1:0]        state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    logic [LANE_W-1:0] cur_lane_reg, cur_lane_next;
    logic [TAP_W-1:0]  scan_tap_reg, scan_tap_next;
    logic [RUN_W-1:0]  match_run_reg, match_run_next;
    logic [SUM_W-1:0]  tap_sum_reg, tap_sum_next;
    logic              locked_reg, locked_next;
    logic [SLIP_W-1:0] slip_tries_reg, slip_tries_next;
    logic [TAP_W-1:0]  chosen_reg, chosen_next;

    // pending result word
    logic [1:0]        res_cmd_reg, res_cmd_next;
    logic              res_slip_reg, res_slip_next;
    logic [LANE_W-1:0] res_lane_reg, res_lane_next;
    logic [TAP_W-1:0]  res_delay_reg, res_delay_next;
    logic              res_rv_reg, res_rv_next;
    logic [LANE_W-1:0] res_rl_reg, res_rl_next;
    logic              res_ra_reg, res_ra_next;
    logic [TAP_W-1:0]  res_rd_reg, res_rd_next;
    logic              res_done_reg, res_done_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        out_cmd_reg;
    logic              out_slip_reg;
    logic [LANE_W-1:0] out_lane_reg;
    logic [TAP_W-1:0]  out_delay_reg;
    logic              out_rv_reg;
    logic [LANE_W-1:0] out_rl_reg;
    logic              out_ra_reg;
    logic [TAP_W-1:0]  out_rd_reg;
    logic              out_done_reg;
    logic              out_load;

    logic              accept;
    logic              word_match;
    logic [4:0]        lane_count;
    logic [4:0]        next_lane_ext;

    logic              stop;
    logic              finished;
    logic [RUN_W-1:0]  run_v;
    logic [SUM_W-1:0]  sum_v;
    logic [SLIP_W-1:0] slip_v;

    logic              div_start;
    logic [SUM_W-1:0]  div_quotient;
    div_status_t       div_status;

    // apb port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lanes_reg    <= RST_LANES_IN_USE;
            fallback_reg <= RST_FALLBACK_DELAY;
            lock_reg     <= RST_LOCK_RUN;
            pattern_reg  <= RST_PATTERN;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_LANES_IN_USE:   lanes_reg    <= pwdata[3:0];
                REG_FALLBACK_DELAY: fallback_reg <= pwdata[4:0];
                REG_LOCK_RUN:       lock_reg     <= pwdata[4:0];
                REG_PATTERN:        pattern_reg  <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_LANES_IN_USE:   prdata = {28'd0, lanes_reg};
            REG_FALLBACK_DELAY: prdata = {27'd0, fallback_reg};
            REG_LOCK_RUN:       prdata = {27'd0, lock_reg};
            REG_PATTERN:        prdata = pattern_reg;
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    // pattern or any byte rotation of it
    assign word_match = (test_word == pattern_reg)
                     || (test_word == {pattern_reg[23:0], pattern_reg[31:24]})
                     || (test_word == {pattern_reg[15:0], pattern_reg[31:16]})
                     || (test_word == {pattern_reg[7:0],  pattern_reg[31:8]});

    always_comb
    begin
        if (lanes_reg == 4'd0)
        begin
            lane_count = 5'd1;
        end
        else if ({1'b0, lanes_reg} > 5'(MAX_LANES))
        begin
            lane_count = 5'(MAX_LANES);
        end
        else
        begin
            lane_count = {1'b0, lanes_reg};
        end
    end

    assign next_lane_ext = 5'(cur_lane_reg) + 5'd1;

    ldt_divider #(
        .DIVD_W (SUM_W),
        .DIVR_W (RUN_W)
    ) u_ldt_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (tap_sum_next),
        .divisor  (match_run_next),
        .quotient (div_quotient),
        .status   (div_status)
    );

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        cur_lane_next   = cur_lane_reg;
        scan_tap_next   = scan_tap_reg;
        match_run_next  = match_run_reg;
        tap_sum_next    = tap_sum_reg;
        locked_next     = locked_reg;
        slip_tries_next = slip_tries_reg;
        chosen_next     = chosen_reg;

        res_cmd_next   = res_cmd_reg;
        res_slip_next  = res_slip_reg;
        res_lane_next  = res_lane_reg;
        res_delay_next = res_delay_reg;
        res_rv_next    = res_rv_reg;
        res_rl_next    = res_rl_reg;
        res_ra_next    = res_ra_reg;
        res_rd_next    = res_rd_reg;
        res_done_next  = res_done_reg;

        div_start = 1'b0;
        stop      = 1'b0;
        finished  = 1'b0;
        run_v     = match_run_reg;
        sum_v     = tap_sum_reg;
        slip_v    = slip_tries_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next     = S_OUT;
                    res_cmd_next   = CMD_NONE;
                    res_slip_next  = 1'b0;
                    res_lane_next  = '0;
                    res_delay_next = '0;
                    res_rv_next    = 1'b0;
                    res_rl_next    = '0;
                    res_ra_next    = 1'b0;
                    res_rd_next    = '0;
                    res_done_next  = 1'b0;

                    if (operation == OP_START)
                    begin
                        phase_next      = PH_SCAN;
                        cur_lane_next   = '0;
                        scan_tap_next   = '0;
                        match_run_next  = '0;
                        tap_sum_next    = '0;
                        locked_next     = 1'b0;
                        slip_tries_next = '0;
                        chosen_next     = '0;
                        res_cmd_next    = CMD_WRITE_READ;
                    end
                    else if (phase_reg == PH_SCAN)
                    begin
                        if (word_match)
                        begin
                            run_v = match_run_reg + RUN_W'(1);
                            sum_v = tap_sum_reg + SUM_W'(scan_tap_reg);
                            if (CMP_W'(run_v) > CMP_W'(lock_reg))
                            begin
                                locked_next = 1'b1;
                            end
                        end
                        else if (locked_reg)
                        begin
                            stop = 1'b1;
                        end
                        else
                        begin
                            run_v = '0;
                            sum_v = '0;
                        end
                        if (scan_tap_reg == LAST_TAP)
                        begin
                            stop = 1'b1;
                        end
                        match_run_next = run_v;
                        tap_sum_next   = sum_v;
                        scan_tap_next  = scan_tap_reg + TAP_W'(1);
                        res_cmd_next   = CMD_WRITE_READ;
                        res_lane_next  = cur_lane_reg;
                        if (stop)
                        begin
                            phase_next      = PH_SLIP;
                            slip_tries_next = '0;
                            if (run_v != '0)
                            begin
                                div_start  = 1'b1;
                                state_next = S_DIV;
                            end
                            else
                            begin
                                chosen_next    = TAP_W'(fallback_reg);
                                res_delay_next = TAP_W'(fallback_reg);
                            end
                        end
                        else
                        begin
                            res_delay_next = scan_tap_reg + TAP_W'(1);
                        end
                    end
                    else if (phase_reg == PH_SLIP)
                    begin
                        if (test_word == pattern_reg)
                        begin
                            finished    = 1'b1;
                            res_ra_next = 1'b1;
                        end
                        else
                        begin
                            res_slip_next   = 1'b1;
                            slip_v          = slip_tries_reg + SLIP_W'(1);
                            slip_tries_next = slip_v;
                            if (slip_v >= SLIP_W'(SLIP_TRIES))
                            begin
                                finished = 1'b1;
                            end
                        end
                        if (!finished)
                        begin
                            res_cmd_next  = CMD_READ;
                            res_lane_next = cur_lane_reg;
                        end
                        else
                        begin
                            res_rv_next = 1'b1;
                            res_rl_next = cur_lane_reg;
                            res_rd_next = chosen_reg;
                            if (next_lane_ext < lane_count)
                            begin
                                phase_next      = PH_SCAN;
                                cur_lane_next   = LANE_W'(next_lane_ext);
                                scan_tap_next   = '0;
                                match_run_next  = '0;
                                tap_sum_next    = '0;
                                locked_next     = 1'b0;
                                slip_tries_next = '0;
                                chosen_next     = '0;
                                res_cmd_next    = CMD_WRITE_READ;
                                res_lane_next   = LANE_W'(next_lane_ext);
                            end
                            else
                            begin
                                res_done_next = 1'b1;
                                phase_next    = PH_IDLE;
                            end
                        end
                    end
                end
            end
            S_DIV:
            begin
                if (div_status.done)
                begin
                    chosen_next    = div_quotient[TAP_W-1:0];
                    res_delay_next = div_quotient[TAP_W-1:0];
                    state_next     = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_IDLE;
            cur_lane_reg   <= '0;
            scan_tap_reg   <= '0;
            match_run_reg  <= '0;
            tap_sum_reg    <= '0;
            locked_reg     <= 1'b0;
            slip_tries_reg <= '0;
            chosen_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            cur_lane_reg   <= cur_lane_next;
            scan_tap_reg   <= scan_tap_next;
            match_run_reg  <= match_run_next;
            tap_sum_reg    <= tap_sum_next;
            locked_reg     <= locked_next;
            slip_tries_reg <= slip_tries_next;
            chosen_reg     <= chosen_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_cmd_reg   <= res_cmd_next;
        res_slip_reg  <= res_slip_next;
        res_lane_reg  <= res_lane_next;
        res_delay_reg <= res_delay_next;
        res_rv_reg    <= res_rv_next;
        res_rl_reg    <= res_rl_next;
        res_ra_reg    <= res_ra_next;
        res_rd_reg    <= res_rd_next;
        res_done_reg  <= res_done_next;
        if (out_load)
        begin
            out_cmd_reg   <= res_cmd_reg;
            out_slip_reg  <= res_slip_reg;
            out_lane_reg  <= res_lane_reg;
            out_delay_reg <= res_delay_reg;
            out_rv_reg    <= res_rv_reg;
            out_rl_reg    <= res_rl_reg;
            out_ra_reg    <= res_ra_reg;
            out_rd_reg    <= res_rd_reg;
            out_done_reg  <= res_done_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign command        = out_cmd_reg;
    assign pulse_bitslip  = out_slip_reg;
    assign lane           = out_lane_reg;
    assign delay          = out_delay_reg;
    assign report_valid   = out_rv_reg;
    assign report_lane    = out_rl_reg;
    assign report_aligned = out_ra_reg;
    assign report_delay   = out_rd_reg;
    assign training_done  = out_done_reg;

endmodule

`default_nettype wire

// File: rtl/core/ldt_checker.sv
// port checker for the lane delay training core, bound to the top level
// depends on ldt_pkg for command codes
`default_nettype none

module ldt_checker
    import ldt_pkg::*;
#(
    parameter int TAP_W  = 5,
    parameter int LANE_W = 3
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_stall,
    input  wire logic              out_valid,
    input  wire logic              out_stall,
    input  wire logic [1:0]        command,
    input  wire logic              pulse_bitslip,
    input  wire logic [LANE_W-1:0] lane,
    input  wire logic [TAP_W-1:0]  delay,
    input  wire logic              report_valid,
    input  wire logic              report_aligned,
    input  wire logic              training_done
);

    // stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(command) && $stable(delay))
        else $error("stalled output word changed");

    // busy after every accepted word
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted on consecutive cycles");

    // a failed lane always ends with a bitslip
    a_fail_slips: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && report_valid && !report_aligned |-> pulse_bitslip)
        else $error("failed report without bitslip");

    // done only with the last report and no further command
    a_done_report: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && training_done |-> report_valid && (command == CMD_NONE))
        else $error("training done without final report");

    // ignored read back gives an empty word
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (command == CMD_NONE) && !report_valid
            |-> !pulse_bitslip && (lane == '0) && (delay == '0))
        else $error("idle word carries data");

endmodule

bind lane_delay_training_with_bitslip_core ldt_checker #(
    .TAP_W  (TAP_W),
    .LANE_W (LANE_W)
) u_ldt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .command        (command),
    .pulse_bitslip  (pulse_bitslip),
    .lane           (lane),
    .delay          (delay),
    .report_valid   (report_valid),
    .report_aligned (report_aligned),
    .training_done  (training_done)
);

`default_nettype wire

// File: tb/lane_delay_training_with_bitslip_core_tb.sv
// testbench for lane_delay_training_with_bitslip_core: directed table, then random training runs
// self-checking against an in-bench lane training predictor; depends on ldt_pkg and the core
`default_nettype none

module lane_delay_training_with_bitslip_core_tb;
    import ldt_pkg::*;

    localparam int LAT_WAIT     = 24;
    localparam int WATCHDOG     = 2000;
    localparam int N_PHASES     = 12;
    localparam int PHASE_ITEMS  = 40;
    localparam int MAX_REPORTED = 10;

    typedef enum logic [1:0] {TRAIN_IDLE, TRAIN_SCAN, TRAIN_SLIP} train_phase_e;

    typedef struct packed {
        logic [1:0] command;
        logic       pulse_bitslip;
        logic [2:0] lane;
        logic [4:0] delay;
        logic       report_valid;
        logic [2:0] report_lane;
        logic       report_aligned;
        logic [4:0] report_delay;
        logic       training_done;
    } lane_cmd_t;

    typedef struct packed {
        logic        op;
        logic [31:0] word;
        logic        typed;
        lane_cmd_t   res;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [LDT_ADDR_W-1:0] paddr = '0;
    logic [LDT_DATA_W-1:0] pwdata = '0;
    logic [LDT_DATA_W-1:0] prdata;
    logic                  pready;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        operation = OP_START;
    logic [31:0] test_word = '0;

    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] command;
    logic       pulse_bitslip;
    logic [2:0] lane;
    logic [4:0] delay;
    logic       report_valid;
    logic [2:0] report_lane;
    logic       report_aligned;
    logic [4:0] report_delay;
    logic       training_done;

    // predictor copy of the registers and the sequencer state
    logic [3:0]   cfg_lanes;
    logic [4:0]   cfg_fallback;
    logic [4:0]   cfg_lock;
    logic [31:0]  cfg_pattern;
    train_phase_e st_phase;
    logic [2:0]   st_lane;
    logic [4:0]   st_tap;
    logic [5:0]   st_run;
    logic [8:0]   st_sum;
    logic         st_locked;
    logic [2:0]   st_tries;
    logic [4:0]   st_chosen;

    lane_cmd_t pending_cmds[$];
    dir_row_t  dir_rows[$];
    lane_cmd_t got_cmd;
    lane_cmd_t want_cmd;

    int n_mismatch = 0;
    int n_items = 0;
    int n_results = 0;
    int n_aligned = 0;
    int n_failed = 0;
    int n_fallback = 0;
    int n_done = 0;
    int idle_cycles = 0;
    int in_quiet = 0;
    int plan_lo = 0;
    int plan_hi = -1;

    always #4 clk = ~clk;

    lane_delay_training_with_bitslip_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .test_word      (test_word),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .command        (command),
        .pulse_bitslip  (pulse_bitslip),
        .lane           (lane),
        .delay          (delay),
        .report_valid   (report_valid),
        .report_lane    (report_lane),
        .report_aligned (report_aligned),
        .report_delay   (report_delay),
        .training_done  (training_done)
    );

    function automatic logic [31:0] rot_bytes(input logic [31:0] p, input int k);
        case (k)
            1:       return {p[23:0], p[31:24]};
            2:       return {p[15:0], p[31:16]};
            3:       return {p[7:0], p[31:8]};
            default: return p;
        endcase
    endfunction

    function automatic logic word_hits(input logic [31:0] w);
        return w == cfg_pattern || w == rot_bytes(cfg_pattern, 1) ||
               w == rot_bytes(cfg_pattern, 2) || w == rot_bytes(cfg_pattern, 3);
    endfunction

    function automatic int lane_limit();
        int n;
        n = cfg_lanes;
        if (n == 0) n = 1;
        if (n > LDT_MAX_LANES) n = LDT_MAX_LANES;
        return n;
    endfunction

    function automatic void start_lane(input int ln);
        st_lane   = 3'(ln);
        st_tap    = '0;
        st_run    = '0;
        st_sum    = '0;
        st_locked = 1'b0;
        st_tries  = '0;
        st_chosen = '0;
        st_phase  = TRAIN_SCAN;
    endfunction

    function automatic lane_cmd_t cmd_res(input logic [1:0] c, input logic [4:0] d);
        lane_cmd_t r;
        r = '0;
        r.command = c;
        r.delay = d;
        return r;
    endfunction

    function automatic lane_cmd_t train_step(input logic op, input logic [31:0] w);
        lane_cmd_t  r;
        logic [5:0] nxt;
        logic       stop;
        logic       fin;
        r = '0;
        r.command = CMD_NONE;
        if (op == OP_START) begin
            start_lane(0);
            r.command = CMD_WRITE_READ;
        end else if (st_phase == TRAIN_SCAN) begin
            stop = 1'b0;
            if (word_hits(w)) begin
                st_run = st_run + 6'd1;
                st_sum = st_sum + 9'(st_tap);
                if (st_run > 6'(cfg_lock)) st_locked = 1'b1;
            end else if (st_locked) begin
                stop = 1'b1;
            end else begin
                st_run = '0;
                st_sum = '0;
            end
            nxt = {1'b0, st_tap} + 6'd1;
            st_tap = nxt[4:0];
            if (int'(nxt) >= LDT_DELAY_TAPS) stop = 1'b1;
            r.lane = st_lane;
            r.command = CMD_WRITE_READ;
            if (stop) begin
                if (st_run != 0) begin
                    st_chosen = 5'(st_sum / 9'(st_run));
                end else begin
                    st_chosen = cfg_fallback;
                    n_fallback++;
                end
                st_tries = '0;
                st_phase = TRAIN_SLIP;
                r.delay = st_chosen;
            end else begin
                r.delay = st_tap;
            end
        end else if (st_phase == TRAIN_SLIP) begin
            fin = 1'b0;
            if (w == cfg_pattern) begin
                fin = 1'b1;
                r.report_aligned = 1'b1;
            end else begin
                r.pulse_bitslip = 1'b1;
                st_tries = st_tries + 3'd1;
                if (int'(st_tries) >= LDT_SLIP_TRIES) fin = 1'b1;
            end
            if (!fin) begin
                r.command = CMD_READ;
                r.lane = st_lane;
            end else begin
                r.report_valid = 1'b1;
                r.report_lane = st_lane;
                r.report_delay = st_chosen;
                if (int'(st_lane) + 1 < lane_limit()) begin
                    start_lane(int'(st_lane) + 1);
                    r.command = CMD_WRITE_READ;
                    r.lane = st_lane;
                end else begin
                    r.training_done = 1'b1;
                    st_phase = TRAIN_IDLE;
                end
            end
        end
        return r;
    endfunction

    function automatic int idle_gap();
        int r;
        if (in_quiet > 0) begin
            in_quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) in_quiet = $urandom_range(20, 60);
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [31:0] noise_word();
        if ($urandom_range(0, 3) == 0) return cfg_pattern ^ (32'd1 << $urandom_range(0, 31));
        return $urandom;
    endfunction

    task automatic next_item(output logic op, output logic [31:0] w);
        int r;
        r = $urandom_range(0, 99);
        op = OP_READ_BACK;
        w = noise_word();
        case (st_phase)
            TRAIN_IDLE: begin
                if (r < 85) op = OP_START;
            end
            TRAIN_SCAN: begin
                if (st_tap == 0) begin
                    case ($urandom_range(0, 9))
                        0: begin plan_lo = 1; plan_hi = 0; end
                        1: begin plan_lo = 0; plan_hi = LDT_DELAY_TAPS - 1; end
                        default: begin
                            plan_lo = $urandom_range(0, LDT_DELAY_TAPS - 1);
                            plan_hi = plan_lo + $urandom_range(0, 11);
                        end
                    endcase
                end
                if (r < 2) begin
                    op = OP_START;
                end else if ((int'(st_tap) >= plan_lo && int'(st_tap) <= plan_hi) != (r >= 94)) begin
                    w = rot_bytes(cfg_pattern, $urandom_range(0, 3));
                end
            end
            default: begin
                if (r < 1) op = OP_START;
                else if (r < 46) w = cfg_pattern;
                else if (r < 76) w = rot_bytes(cfg_pattern, $urandom_range(1, 3));
            end
        endcase
    endtask

    task automatic send_word(input logic op, input logic [31:0] w, input logic typed,
                             input lane_cmd_t typed_res);
        int        gap;
        lane_cmd_t res;
        gap = idle_gap();
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        operation <= op;
        test_word <= w;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        if (op == OP_START || st_phase != TRAIN_IDLE) n_items++;
        res = train_step(op, w);
        pending_cmds.push_back(typed ? typed_res : res);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge clk);
        repeat (LAT_WAIT) @(posedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1) @(posedge clk);
        case (idx)
            REG_LANES_IN_USE:   cfg_lanes = val[3:0];
            REG_FALLBACK_DELAY: cfg_fallback = val[4:0];
            REG_LOCK_RUN:       cfg_lock = val[4:0];
            default:            cfg_pattern = val;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic add_row(input logic op, input logic [31:0] w, input logic typed,
                           input lane_cmd_t res);
        dir_row_t row;
        row.op = op;
        row.word = w;
        row.typed = typed;
        row.res = res;
        dir_rows.push_back(row);
    endtask

    task automatic note_mismatch(input string what, input lane_cmd_t want, input lane_cmd_t got);
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTED) begin
            $display("%0t %s: expected cmd=%0d slip=%0d lane=%0d dly=%0d rv=%0d rl=%0d ra=%0d rd=%0d done=%0d",
                     $realtime, what, want.command, want.pulse_bitslip, want.lane, want.delay,
                     want.report_valid, want.report_lane, want.report_aligned, want.report_delay,
                     want.training_done);
            $display("%0t %s:   actual cmd=%0d slip=%0d lane=%0d dly=%0d rv=%0d rl=%0d ra=%0d rd=%0d done=%0d",
                     $realtime, what, got.command, got.pulse_bitslip, got.lane, got.delay,
                     got.report_valid, got.report_lane, got.report_aligned, got.report_delay,
                     got.training_done);
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
            got_cmd = {command, pulse_bitslip, lane, delay, report_valid, report_lane,
                       report_aligned, report_delay, training_done};
            n_results++;
            if (pending_cmds.size() == 0) begin
                note_mismatch("unexpected word", '0, got_cmd);
            end else begin
                want_cmd = pending_cmds.pop_front();
                if (got_cmd !== want_cmd) note_mismatch("word mismatch", want_cmd, got_cmd);
            end
            if (got_cmd.report_valid === 1'b1) begin
                if (got_cmd.report_aligned === 1'b1) n_aligned++;
                else n_failed++;
            end
            if (got_cmd.training_done === 1'b1) n_done++;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_stall == 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG) begin
            $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                     WATCHDOG, pending_cmds.size());
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stall_gen
        int hold;
        int free;
        int r;
        hold = 0;
        free = 0;
        forever begin
            @(negedge clk);
            if (hold > 0) begin
                out_stall <= 1'b1;
                hold--;
            end else begin
                out_stall <= 1'b0;
                if (free > 0) begin
                    free--;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 70) hold = $urandom_range(1, 2);
                    else if (r < 95) hold = $urandom_range(3, 8);
                    else hold = $urandom_range(15, 40);
                    if ($urandom_range(0, 9) == 0) free = $urandom_range(60, 200);
                    else free = $urandom_range(0, 6);
                end
            end
        end
    end

    initial begin : stimulus
        logic        op;
        logic [31:0] w;
        logic [31:0] p;
        int          sent;
        cfg_lanes    = RST_LANES_IN_USE;
        cfg_fallback = RST_FALLBACK_DELAY;
        cfg_lock     = RST_LOCK_RUN;
        cfg_pattern  = RST_PATTERN;
        st_phase     = TRAIN_IDLE;
        st_lane      = '0;
        st_tap       = '0;
        st_run       = '0;
        st_sum       = '0;
        st_locked    = 1'b0;
        st_tries     = '0;
        st_chosen    = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // read back while idle, first lane with a locked window, bitslip then exact
        p = RST_PATTERN;
        add_row(OP_READ_BACK, 32'h0000_0000, 1'b1, cmd_res(CMD_NONE, 5'd0));
        add_row(OP_READ_BACK, 32'hFFFF_FFFF, 1'b1, cmd_res(CMD_NONE, 5'd0));
        add_row(OP_START, 32'h0000_0000, 1'b1, cmd_res(CMD_WRITE_READ, 5'd0));
        add_row(OP_READ_BACK, 32'h0000_0000, 1'b1, cmd_res(CMD_WRITE_READ, 5'd1));
        add_row(OP_READ_BACK, p, 1'b1, cmd_res(CMD_WRITE_READ, 5'd2));
        add_row(OP_READ_BACK, rot_bytes(p, 1), 1'b0, '0);
        add_row(OP_READ_BACK, rot_bytes(p, 2), 1'b0, '0);
        add_row(OP_READ_BACK, rot_bytes(p, 3), 1'b0, '0);
        add_row(OP_READ_BACK, p, 1'b0, '0);
        add_row(OP_READ_BACK, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(OP_READ_BACK, rot_bytes(p, 1), 1'b0, '0);
        add_row(OP_READ_BACK, p, 1'b0, '0);
        // restart while training, run broken before lock, then four failed slips
        add_row(OP_START, 32'hFFFF_FFFF, 1'b1, cmd_res(CMD_WRITE_READ, 5'd0));
        add_row(OP_READ_BACK, p, 1'b0, '0);
        add_row(OP_READ_BACK, p ^ 32'h8000_0000, 1'b0, '0);
        add_row(OP_READ_BACK, rot_bytes(p, 3), 1'b0, '0);
        add_row(OP_READ_BACK, p, 1'b0, '0);
        add_row(OP_READ_BACK, rot_bytes(p, 2), 1'b0, '0);
        add_row(OP_READ_BACK, rot_bytes(p, 1), 1'b0, '0);
        add_row(OP_READ_BACK, p, 1'b0, '0);
        add_row(OP_READ_BACK, 32'h0000_0001, 1'b0, '0);
        add_row(OP_READ_BACK, 32'h0000_0000, 1'b0, '0);
        add_row(OP_READ_BACK, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(OP_READ_BACK, rot_bytes(p, 2), 1'b0, '0);
        add_row(OP_READ_BACK, p ^ 32'h0000_0001, 1'b0, '0);
        foreach (dir_rows[i]) send_word(dir_rows[i].op, dir_rows[i].word, dir_rows[i].typed,
                                        dir_rows[i].res);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    reg_write(REG_LANES_IN_USE, 32'd0);
                    reg_write(REG_FALLBACK_DELAY, 32'd0);
                    reg_write(REG_LOCK_RUN, 32'd0);
                    reg_write(REG_PATTERN, 32'h0000_0000);
                end
                1: begin
                    reg_write(REG_LANES_IN_USE, 32'd15);
                    reg_write(REG_FALLBACK_DELAY, 32'd31);
                    reg_write(REG_LOCK_RUN, 32'd31);
                    reg_write(REG_PATTERN, 32'hFFFF_FFFF);
                end
                2: begin
                    reg_write(REG_LANES_IN_USE, 32'd1);
                    reg_write(REG_FALLBACK_DELAY, 32'd31);
                    reg_write(REG_LOCK_RUN, 32'd0);
                    reg_write(REG_PATTERN, $urandom);
                end
                3: begin
                    reg_write(REG_LANES_IN_USE, 32'd8);
                    reg_write(REG_FALLBACK_DELAY, 32'd0);
                    reg_write(REG_LOCK_RUN, 32'd31);
                    reg_write(REG_PATTERN, RST_PATTERN);
                end
                default: begin
                    reg_write(REG_LANES_IN_USE, $urandom);
                    reg_write(REG_FALLBACK_DELAY, $urandom_range(0, 31));
                    if ($urandom_range(0, 3) == 0) reg_write(REG_LOCK_RUN, $urandom_range(0, 31));
                    else reg_write(REG_LOCK_RUN, $urandom_range(0, 6));
                    if ($urandom_range(0, 3) == 0) reg_write(REG_PATTERN, {4{8'($urandom)}});
                    else reg_write(REG_PATTERN, $urandom);
                end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) == 0) wait_idle();
                next_item(op, w);
                if (op == OP_START || st_phase != TRAIN_IDLE) sent++;
                send_word(op, w, 1'b0, '0);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge clk);
        repeat (LAT_WAIT) @(posedge clk);
        $display("covered %0d words in, %0d words out over %0d register settings",
                 n_items, n_results, N_PHASES + 1);
        $display("lanes aligned %0d, failed %0d, fallback taps %0d, full trainings %0d",
                 n_aligned, n_failed, n_fallback, n_done);
        if (n_mismatch == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
